FILE: design/sut_pkg.sv
package sut_pkg;

  localparam int MAX_ROWS      = 1024;
  localparam int MAX_ENTRIES   = 8192;
  localparam int FRACTION_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ROW_CNT_W = ROW_W + 1;
  localparam int ENT_W     = $clog2(MAX_ENTRIES);
  localparam int ENT_CNT_W = ENT_W + 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DIVD_W    = DATA_W + FRACTION_BITS;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  typedef enum logic [2:0] {
    K_LOAD_RHS   = 3'd0,
    K_LOAD_ENTRY = 3'd1,
    K_SOLVE      = 3'd2,
    K_READ       = 3'd3,
    K_CLEAR      = 3'd4
  } kind_e;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_ORDER = 3'd2;
  localparam logic [2:0] ST_DIAG  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [DATA_W-1:0] val;
  } entry_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

FILE: design/sut_div.sv
module sut_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sut_pkg::DIVD_W-1:0]       dividend_i,
  input  logic [sut_pkg::DATA_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [sut_pkg::DIVD_W-1:0]       quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [sut_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [sut_pkg::DATA_W-1:0]       rem_q, rem_d;
  logic [sut_pkg::DATA_W-1:0]       dvs_q, dvs_d;
  logic [sut_pkg::DIVD_W-1:0]       quo_q, quo_d;
  logic [sut_pkg::DATA_W:0]         trial;
  logic                             fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[sut_pkg::DIVD_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? sut_pkg::DATA_W'(trial - {1'b0, dvs_q}) : trial[sut_pkg::DATA_W-1:0];
      quo_d = {quo_q[sut_pkg::DIVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == sut_pkg::DIV_CNT_W'(sut_pkg::DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/sparse_upper_triangular_solve_core.sv
// Load, clear and unknown items finish from idle; the result strobe follows the next cycle.
// A read goes through S_READ for the registered vector memory read.
// A solve uses a 48-step divider per row and read, check and subtract states per entry.
// busy_o is high while an item is at work; the receiver cannot stall the result.
// Reset clears the entry count and sets row_count to 1024; the vector memory is not cleared.
module sparse_upper_triangular_solve_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [2:0]                           kind_i,
  input  logic [sut_pkg::ROW_W-1:0]            row_i,
  input  logic [sut_pkg::ROW_W-1:0]            col_i,
  input  logic signed [sut_pkg::DATA_W-1:0]    value_i,
  input  logic                                 cfg_we_i,
  input  logic [sut_pkg::ROW_CNT_W-1:0]        cfg_data_i,
  output logic                                 done_o,
  output logic [2:0]                           status_o,
  output logic signed [sut_pkg::DATA_W-1:0]    solution_o,
  output logic [sut_pkg::ROW_W-1:0]            bad_row_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_DIAG  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EREAD = 3'd5;
  localparam logic [2:0] S_ECHK  = 3'd6;
  localparam logic [2:0] S_SUB   = 3'd7;

  localparam int DW = sut_pkg::DATA_W;
  localparam int PW = sut_pkg::PROD_W;

  logic [2:0]                          state_q, state_d;
  logic [sut_pkg::ROW_CNT_W-1:0]       row_count_q, row_count_d;
  logic [sut_pkg::ENT_CNT_W-1:0]       entries_q, entries_d;
  logic [sut_pkg::ROW_W-1:0]           last_row_q, last_row_d;
  logic [sut_pkg::ROW_W-1:0]           last_col_q, last_col_d;
  logic [sut_pkg::ROW_CNT_W-1:0]       i_q, i_d;
  logic [sut_pkg::ENT_CNT_W-1:0]       e_q, e_d;
  logic signed [DW-1:0]                x_q, x_d;
  logic signed [PW-1:0]                prod_q, prod_d;
  logic [sut_pkg::ROW_W-1:0]           j_q, j_d;
  logic                                sign_q, sign_d;
  logic                                done_q, done_d;
  logic [2:0]                          status_q, status_d;
  logic signed [DW-1:0]                sol_q, sol_d;
  logic [sut_pkg::ROW_W-1:0]           bad_q, bad_d;

  logic signed [DW-1:0]                vec_mem [sut_pkg::MAX_ROWS];
  logic signed [DW-1:0]                vec_rd_q;
  logic                                vec_we;
  logic [sut_pkg::ROW_W-1:0]           vec_waddr, vec_raddr;
  logic signed [DW-1:0]                vec_wdata;

  sut_pkg::entry_t                     ent_mem [sut_pkg::MAX_ENTRIES];
  sut_pkg::entry_t                     ent_rd_q;
  sut_pkg::entry_t                     ent_wdata;
  logic                                ent_we;

  logic                                accept;
  logic                                row_ok, col_ok;
  logic [2:0]                          ld_status;
  logic                                div_start, div_done;
  logic [sut_pkg::DIVD_W-1:0]          div_dividend, div_quo;
  logic [DW-1:0]                       div_divisor;
  logic [DW-1:0]                       b_mag, d_mag;
  logic signed [DW-1:0]                x_new;
  logic signed [PW-1:0]                bias, prod_t;
  logic [sut_pkg::ROW_CNT_W-1:0]       cfg_clamped;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = state_q != S_IDLE;
  assign row_ok = {1'b0, row_i} < row_count_q;
  assign col_ok = {1'b0, col_i} < row_count_q;

  always_comb begin
    if (!row_ok || !col_ok) begin
      ld_status = sut_pkg::ST_RANGE;
    end else if (col_i < row_i) begin
      ld_status = sut_pkg::ST_ORDER;
    end else if ((entries_q != '0) && ((row_i < last_row_q) ||
                 ((row_i == last_row_q) && (col_i <= last_col_q)))) begin
      ld_status = sut_pkg::ST_ORDER;
    end else if (entries_q >= sut_pkg::ENT_CNT_W'(sut_pkg::MAX_ENTRIES)) begin
      ld_status = sut_pkg::ST_FULL;
    end else begin
      ld_status = sut_pkg::ST_OK;
    end
  end

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamped = sut_pkg::ROW_CNT_W'(1);
    end else if (cfg_data_i > sut_pkg::ROW_CNT_W'(sut_pkg::MAX_ROWS)) begin
      cfg_clamped = sut_pkg::ROW_CNT_W'(sut_pkg::MAX_ROWS);
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  assign b_mag        = vec_rd_q[DW-1] ? DW'(-vec_rd_q) : DW'(vec_rd_q);
  assign d_mag        = ent_rd_q.val[DW-1] ? DW'(-ent_rd_q.val) : DW'(ent_rd_q.val);
  assign div_dividend = {b_mag, {sut_pkg::FRACTION_BITS{1'b0}}};
  assign div_divisor  = d_mag;

  always_comb begin
    if (!sign_q) begin
      if (div_quo > sut_pkg::DIVD_W'({1'b0, {(DW-1){1'b1}}})) begin
        x_new = {1'b0, {(DW-1){1'b1}}};
      end else begin
        x_new = div_quo[DW-1:0];
      end
    end else begin
      if (div_quo > sut_pkg::DIVD_W'({1'b1, {(DW-1){1'b0}}})) begin
        x_new = {1'b1, {(DW-1){1'b0}}};
      end else begin
        x_new = -div_quo[DW-1:0];
      end
    end
  end

  assign bias   = prod_q[PW-1] ? PW'({sut_pkg::FRACTION_BITS{1'b1}}) : '0;
  assign prod_t = (prod_q + bias) >>> sut_pkg::FRACTION_BITS;

  always_comb begin
    state_d     = state_q;
    row_count_d = cfg_we_i ? cfg_clamped : row_count_q;
    entries_d   = entries_q;
    last_row_d  = last_row_q;
    last_col_d  = last_col_q;
    i_d         = i_q;
    e_d         = e_q;
    x_d         = x_q;
    prod_d      = prod_q;
    j_d         = j_q;
    sign_d      = sign_q;
    done_d      = 1'b0;
    status_d    = status_q;
    sol_d       = sol_q;
    bad_d       = bad_q;
    vec_we      = 1'b0;
    vec_waddr   = row_i;
    vec_wdata   = value_i;
    vec_raddr   = row_i;
    ent_we      = 1'b0;
    ent_wdata   = '{row: row_i, col: col_i, val: value_i};
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = sut_pkg::ST_OK;
          sol_d    = '0;
          bad_d    = '0;
          case (kind_i)
            sut_pkg::K_LOAD_RHS: begin
              done_d = 1'b1;
              if (!row_ok) begin
                status_d = sut_pkg::ST_RANGE;
              end else begin
                vec_we = 1'b1;
              end
            end
            sut_pkg::K_LOAD_ENTRY: begin
              done_d   = 1'b1;
              status_d = ld_status;
              if (ld_status == sut_pkg::ST_OK) begin
                ent_we     = 1'b1;
                entries_d  = entries_q + 1'b1;
                last_row_d = row_i;
                last_col_d = col_i;
              end
            end
            sut_pkg::K_SOLVE: begin
              i_d     = '0;
              e_d     = '0;
              state_d = S_ROW;
            end
            sut_pkg::K_READ: begin
              if (!row_ok) begin
                done_d   = 1'b1;
                status_d = sut_pkg::ST_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            sut_pkg::K_CLEAR: begin
              done_d     = 1'b1;
              entries_d  = '0;
              last_row_d = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        done_d  = 1'b1;
        sol_d   = vec_rd_q;
        state_d = S_IDLE;
      end
      S_ROW: begin
        vec_raddr = i_q[sut_pkg::ROW_W-1:0];
        if (i_q >= row_count_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (e_q >= entries_q) begin
          done_d   = 1'b1;
          status_d = sut_pkg::ST_DIAG;
          bad_d    = i_q[sut_pkg::ROW_W-1:0];
          state_d  = S_IDLE;
        end else begin
          state_d = S_DIAG;
        end
      end
      S_DIAG: begin
        if ((ent_rd_q.row != i_q[sut_pkg::ROW_W-1:0]) ||
            (ent_rd_q.col != i_q[sut_pkg::ROW_W-1:0]) || (ent_rd_q.val == '0)) begin
          done_d   = 1'b1;
          status_d = sut_pkg::ST_DIAG;
          bad_d    = i_q[sut_pkg::ROW_W-1:0];
          state_d  = S_IDLE;
        end else begin
          div_start = 1'b1;
          sign_d    = vec_rd_q[DW-1] ^ ent_rd_q.val[DW-1];
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          vec_we    = 1'b1;
          vec_waddr = i_q[sut_pkg::ROW_W-1:0];
          vec_wdata = x_new;
          x_d       = x_new;
          e_d       = e_q + 1'b1;
          state_d   = S_EREAD;
        end
      end
      S_EREAD: begin
        if (e_q >= entries_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_ROW;
        end else begin
          state_d = S_ECHK;
        end
      end
      S_ECHK: begin
        vec_raddr = ent_rd_q.col;
        if (ent_rd_q.row != i_q[sut_pkg::ROW_W-1:0]) begin
          i_d     = i_q + 1'b1;
          state_d = S_ROW;
        end else if ({1'b0, ent_rd_q.col} >= row_count_q) begin
          e_d     = e_q + 1'b1;
          state_d = S_EREAD;
        end else begin
          prod_d  = x_q * ent_rd_q.val;
          j_d     = ent_rd_q.col;
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        vec_we    = 1'b1;
        vec_waddr = j_q;
        vec_wdata = sut_pkg::sat32(PW'(vec_rd_q) - prod_t);
        e_d       = e_q + 1'b1;
        state_d   = S_EREAD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_rd_q <= vec_mem[vec_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[entries_q[sut_pkg::ENT_W-1:0]] <= ent_wdata;
    end
    ent_rd_q <= ent_mem[e_q[sut_pkg::ENT_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_count_q <= sut_pkg::ROW_CNT_W'(sut_pkg::MAX_ROWS);
      entries_q   <= '0;
      last_row_q  <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_count_q <= row_count_d;
      entries_q   <= entries_d;
      last_row_q  <= last_row_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_col_q <= last_col_d;
    i_q        <= i_d;
    e_q        <= e_d;
    x_q        <= x_d;
    prod_q     <= prod_d;
    j_q        <= j_d;
    sign_q     <= sign_d;
    status_q   <= status_d;
    sol_q      <= sol_d;
    bad_q      <= bad_d;
  end

  sut_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign solution_o = sol_q;
  assign bad_row_o  = bad_q;

endmodule

FILE: design/sut_checker.sv
module sut_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              done_o,
  input logic [2:0]                        status_o,
  input logic signed [sut_pkg::DATA_W-1:0] solution_o,
  input logic [sut_pkg::ROW_W-1:0]         bad_row_o
);

  // Every accepted beat is either followed by a result strobe or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o || busy_o))
    else $error("accepted beat neither answered nor held busy");

  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy fell without a result");

  a_bad_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != sut_pkg::ST_DIAG)) |-> (bad_row_o == '0))
    else $error("bad_row set without a diagonal error");

  a_sol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != sut_pkg::ST_OK)) |-> (solution_o == '0))
    else $error("solution set on an error");

endmodule

bind sparse_upper_triangular_solve_core sut_checker u_sut_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .status_o   (status_o),
  .solution_o (solution_o),
  .bad_row_o  (bad_row_o)
);
